// ===== rtl/fla_pkg.sv =====
package fla_pkg;

	localparam int RAW_W   = 10;
	localparam int LEVEL_W = 7;
	localparam int QUO_W   = 7;
	localparam int DIV_DW  = 17;
	localparam int DIV_VW  = 10;
	localparam int CNT_W   = 3;

	localparam logic [LEVEL_W-1:0] FULL_SCALE = 7'd100;
	localparam logic [RAW_W-1:0]   RAW_MAX    = 10'h3FF;

	localparam logic REG_ADC_LOW  = 1'b0;
	localparam logic REG_ADC_HIGH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PCT_START,
		ST_PCT_WAIT,
		ST_UPDATE,
		ST_AVG_START,
		ST_AVG_WAIT,
		ST_DONE
	} fla_state_t;

	typedef enum logic {
		DIV_PCT,
		DIV_AVG
	} fla_div_sel_t;

	typedef struct packed {
		logic         load_x;
		logic         div_start;
		fla_div_sel_t div_sel;
		logic         update;
		logic         load_out;
	} fla_cmd_t;

	typedef struct packed {
		logic div_busy;
	} fla_stat_t;

endpackage

// ===== rtl/fla_div.sv =====
module fla_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fla_pkg::DIV_DW-1:0]    dividend,
	input  logic [fla_pkg::DIV_VW-1:0]    divisor,
	output logic [fla_pkg::QUO_W-1:0]     quotient,
	output logic                          busy
);

	logic [fla_pkg::DIV_DW-1:0] rem_q;
	logic [fla_pkg::DIV_DW-1:0] dsh_q;
	logic [fla_pkg::QUO_W-1:0]  quo_q;
	logic [fla_pkg::CNT_W-1:0]  cnt_q;
	logic                       busy_q;
	logic                       fits;

	// quotient is known to stay below 2**QUO_W, so only QUO_W restoring steps
	assign fits = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= fla_pkg::CNT_W'(fla_pkg::QUO_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= fla_pkg::DIV_DW'(divisor) << (fla_pkg::QUO_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[fla_pkg::QUO_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign busy     = busy_q;

endmodule

// ===== rtl/fla_datapath.sv =====
module fla_datapath #(
	parameter int DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fla_pkg::fla_cmd_t            cmd,
	output fla_pkg::fla_stat_t           stat,
	input  logic                         cfg_we,
	input  logic                         cfg_addr,
	input  logic [fla_pkg::RAW_W-1:0]    cfg_wdata,
	input  logic [fla_pkg::RAW_W-1:0]    raw_sample,
	output logic [fla_pkg::LEVEL_W-1:0]  level_percent,
	output logic                         window_full,
	output logic [fla_pkg::RAW_W-1:0]    lowest_seen,
	output logic [fla_pkg::RAW_W-1:0]    highest_seen
);

	localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int TW = $clog2(DEPTH * 100 + 1);
	localparam logic [SW-1:0] SLOT_LAST = SW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL  = CW'(DEPTH);

	logic [fla_pkg::RAW_W-1:0]   adc_low_q;
	logic [fla_pkg::RAW_W-1:0]   adc_high_q;
	logic [fla_pkg::RAW_W-1:0]   x_q;
	logic [fla_pkg::RAW_W-1:0]   min_q;
	logic [fla_pkg::RAW_W-1:0]   max_q;
	logic [SW-1:0]               slot_q;
	logic [CW-1:0]               count_q;
	logic [TW-1:0]               total_q;
	logic [fla_pkg::LEVEL_W-1:0] ring [DEPTH];
	logic [fla_pkg::LEVEL_W-1:0] ring_rd_q;
	logic [fla_pkg::LEVEL_W-1:0] level_q;
	logic                        full_q;
	logic [fla_pkg::RAW_W-1:0]   lowest_q;
	logic [fla_pkg::RAW_W-1:0]   highest_q;

	logic                        no_window;
	logic                        full;
	logic [fla_pkg::RAW_W-1:0]   x_clamp;
	logic [fla_pkg::RAW_W-1:0]   span;
	logic [fla_pkg::DIV_DW-1:0]  scaled;
	logic [fla_pkg::DIV_DW-1:0]  div_dividend;
	logic [fla_pkg::DIV_VW-1:0]  div_divisor;
	logic [fla_pkg::QUO_W-1:0]   quotient;
	logic [fla_pkg::LEVEL_W-1:0] pct;
	logic [fla_pkg::LEVEL_W-1:0] leaving;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adc_low_q  <= '0;
			adc_high_q <= fla_pkg::RAW_MAX;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				fla_pkg::REG_ADC_LOW:  adc_low_q  <= cfg_wdata;
				fla_pkg::REG_ADC_HIGH: adc_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign no_window = (adc_high_q <= adc_low_q);
	assign full      = (count_q == CNT_FULL);
	assign span      = adc_high_q - adc_low_q;

	always_comb begin
		if (x_q < adc_low_q) begin
			x_clamp = adc_low_q;
		end else if (x_q > adc_high_q) begin
			x_clamp = adc_high_q;
		end else begin
			x_clamp = x_q;
		end
	end

	assign scaled = fla_pkg::DIV_DW'(x_clamp - adc_low_q) * fla_pkg::DIV_DW'(fla_pkg::FULL_SCALE);

	always_comb begin
		if (cmd.div_sel == fla_pkg::DIV_AVG) begin
			div_dividend = fla_pkg::DIV_DW'(total_q);
			div_divisor  = fla_pkg::DIV_VW'(count_q);
		end else begin
			div_dividend = scaled;
			div_divisor  = span;
		end
	end

	fla_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (quotient),
		.busy     (stat.div_busy)
	);

	// with no usable window the divider result is ignored
	assign pct     = no_window ? fla_pkg::FULL_SCALE : fla_pkg::FULL_SCALE - quotient;
	assign leaving = full ? ring_rd_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= fla_pkg::RAW_MAX;
			max_q   <= '0;
			slot_q  <= '0;
			count_q <= '0;
			total_q <= '0;
		end else begin
			if (cmd.load_x) begin
				if (raw_sample < min_q) begin
					min_q <= raw_sample;
				end
				if (raw_sample > max_q) begin
					max_q <= raw_sample;
				end
			end
			if (cmd.update) begin
				total_q <= TW'(total_q - TW'(leaving) + TW'(pct));
				slot_q  <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
				if (!full) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_x) begin
			x_q <= raw_sample;
		end
		if (cmd.update) begin
			ring[slot_q] <= pct;
		end
		ring_rd_q <= ring[slot_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			level_q   <= quotient;
			full_q    <= full;
			lowest_q  <= min_q;
			highest_q <= max_q;
		end
	end

	assign level_percent = level_q;
	assign window_full   = full_q;
	assign lowest_seen   = lowest_q;
	assign highest_seen  = highest_q;

endmodule

// ===== rtl/fla_ctrl.sv =====
module fla_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  fla_pkg::fla_stat_t  stat,
	output fla_pkg::fla_cmd_t   cmd
);

	fla_pkg::fla_state_t state_q;
	fla_pkg::fla_state_t state_d;
	logic                out_valid_q;
	logic                out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fla_pkg::ST_IDLE:      if (in_valid) state_d = fla_pkg::ST_PCT_START;
			fla_pkg::ST_PCT_START: state_d = fla_pkg::ST_PCT_WAIT;
			fla_pkg::ST_PCT_WAIT:  if (!stat.div_busy) state_d = fla_pkg::ST_UPDATE;
			fla_pkg::ST_UPDATE:    state_d = fla_pkg::ST_AVG_START;
			fla_pkg::ST_AVG_START: state_d = fla_pkg::ST_AVG_WAIT;
			fla_pkg::ST_AVG_WAIT:  if (!stat.div_busy) state_d = fla_pkg::ST_DONE;
			fla_pkg::ST_DONE:      if (out_free) state_d = fla_pkg::ST_IDLE;
			default:               state_d = fla_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.div_sel   = fla_pkg::DIV_PCT;
		in_ready      = 1'b0;
		unique case (state_q)
			fla_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.load_x = in_valid;
			end
			fla_pkg::ST_PCT_START: cmd.div_start = 1'b1;
			fla_pkg::ST_UPDATE:    cmd.update = 1'b1;
			fla_pkg::ST_AVG_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = fla_pkg::DIV_AVG;
			end
			fla_pkg::ST_AVG_WAIT:  cmd.div_sel = fla_pkg::DIV_AVG;
			fla_pkg::ST_DONE:      cmd.load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fla_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/fuel_level_averager.sv =====
// Fuel level averager: each raw sample accepted on s_* updates the lowest and
// highest readings seen, is clamped to [adc_low, adc_high] and mapped inverted
// onto 0..100 percent (100 at adc_low, 0 at adc_high, 100 for every sample when
// adc_high <= adc_low). The percent enters a ring of DEPTH entries and one
// result per sample leaves on m_*: the floor average of the stored percents,
// a flag set once DEPTH samples are stored, and the lowest/highest readings.
// One sample is processed at a time, and the next sample can be taken in the
// same cycle as its result becomes valid. Each sample makes two 7-step passes
// through one shared restoring divider (percent scaling, then the average),
// each with a start state and a wait state, plus the update, result and idle
// states. A finished result sits in an output register, so the next sample is
// taken while it waits.
// Write adc_low / adc_high only while the block is idle.
module fuel_level_averager #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [9:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // raw_sample[9:0], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // level_percent[6:0], window_full[7],
	                               // lowest_seen[17:8], highest_seen[27:18], zero pad
);

	fla_pkg::fla_cmd_t           cmd;
	fla_pkg::fla_stat_t          stat;
	logic [fla_pkg::LEVEL_W-1:0] level_percent;
	logic                        window_full;
	logic [fla_pkg::RAW_W-1:0]   lowest_seen;
	logic [fla_pkg::RAW_W-1:0]   highest_seen;

	fla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fla_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.raw_sample    (s_tdata[fla_pkg::RAW_W-1:0]),
		.level_percent (level_percent),
		.window_full   (window_full),
		.lowest_seen   (lowest_seen),
		.highest_seen  (highest_seen)
	);

	assign m_tdata = {4'b0, highest_seen, lowest_seen, window_full, level_percent};

endmodule

// ===== rtl/fla_checker.sv =====
module fla_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one sample at a time: input closes right after a transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[6:0] <= 7'd100)
		else $error("level above full scale");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[17:8] <= m_tdata[27:18] && m_tdata[31:28] == 4'b0)
		else $error("lowest above highest or pad bits set");

endmodule

bind fuel_level_averager fla_checker u_fla_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/sv/fuel_level_checker.sv =====
`timescale 1ns / 1ps

module fuel_level_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [9:0]  cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	output int          error_count,
	output int          expected_left
);

	localparam int RING_DEPTH = 16;

	typedef struct packed {
		logic [fla_pkg::LEVEL_W-1:0] level;
		logic                        full;
		logic [fla_pkg::RAW_W-1:0]   lowest;
		logic [fla_pkg::RAW_W-1:0]   highest;
	} level_report_t;

	// shadow of the block state
	logic [fla_pkg::LEVEL_W-1:0] pct_ring [RING_DEPTH];
	logic [3:0]                  slot;
	logic [4:0]                  stored;
	logic [10:0]                 total;
	logic [fla_pkg::RAW_W-1:0]   low_mark;
	logic [fla_pkg::RAW_W-1:0]   high_mark;
	logic [fla_pkg::RAW_W-1:0]   win_low;
	logic [fla_pkg::RAW_W-1:0]   win_high;

	level_report_t pending_levels [$];
	level_report_t want_levels;

	task automatic report_mismatch(input string what, input int got, input int want);
		error_count++;
		$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	function automatic logic [fla_pkg::LEVEL_W-1:0] scale_to_percent(
		input logic [fla_pkg::RAW_W-1:0] x);
		int unsigned xc;
		int unsigned span;
		// no usable window: equal or inverted bounds
		if (win_high <= win_low)
			return fla_pkg::FULL_SCALE;
		xc = x;
		if (x < win_low)
			xc = win_low;
		else if (x > win_high)
			xc = win_high;
		span = win_high - win_low;
		return fla_pkg::LEVEL_W'(fla_pkg::FULL_SCALE
			- ((xc - win_low) * fla_pkg::FULL_SCALE) / span);
	endfunction

	task automatic predict_sample(input logic [fla_pkg::RAW_W-1:0] x);
		logic [fla_pkg::LEVEL_W-1:0] pct;
		level_report_t               r;
		if (x < low_mark)
			low_mark = x;
		if (x > high_mark)
			high_mark = x;
		pct = scale_to_percent(x);
		// oldest entry drops out once the ring has wrapped
		if (stored >= RING_DEPTH)
			total = total - pct_ring[slot];
		pct_ring[slot] = pct;
		total = total + pct;
		slot = slot + 1'b1;
		if (stored < RING_DEPTH)
			stored = stored + 1'b1;
		r.level   = fla_pkg::LEVEL_W'(total / stored);
		r.full    = (stored >= RING_DEPTH);
		r.lowest  = low_mark;
		r.highest = high_mark;
		pending_levels.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot          = '0;
			stored        = '0;
			total         = '0;
			low_mark      = fla_pkg::RAW_MAX;
			high_mark     = '0;
			win_low       = '0;
			win_high      = fla_pkg::RAW_MAX;
			error_count   = 0;
			pending_levels.delete();
			expected_left = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					fla_pkg::REG_ADC_LOW: win_low = cfg_wdata;
					fla_pkg::REG_ADC_HIGH: win_high = cfg_wdata;
					default: ;
				endcase
			end
			// results first, so one arriving with nothing queued is caught
			if (m_tvalid && m_tready) begin
				if (pending_levels.size() == 0) begin
					report_mismatch("result with nothing expected", m_tdata, 0);
				end else begin
					want_levels = pending_levels.pop_front();
					if (m_tdata[6:0] !== want_levels.level)
						report_mismatch("level_percent", m_tdata[6:0], want_levels.level);
					if (m_tdata[7] !== want_levels.full)
						report_mismatch("window_full", m_tdata[7], want_levels.full);
					if (m_tdata[17:8] !== want_levels.lowest)
						report_mismatch("lowest_seen", m_tdata[17:8], want_levels.lowest);
					if (m_tdata[27:18] !== want_levels.highest)
						report_mismatch("highest_seen", m_tdata[27:18], want_levels.highest);
				end
			end
			if (s_tvalid && s_tready)
				predict_sample(s_tdata[fla_pkg::RAW_W-1:0]);
			expected_left = pending_levels.size();
		end
	end

endmodule

// ===== tb/sv/fuel_level_averager_test.sv =====
`timescale 1ns / 1ps

module fuel_level_averager_test;

	localparam int STALL_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 50;
	localparam int DRAIN_CYCLES  = 30;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_addr;
	logic [9:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	int error_count;
	int expected_left;
	int idle_run = 0;
	bit no_idle;
	bit hold_request;

	always #5 clk = ~clk;

	fuel_level_averager DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	fuel_level_checker level_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.error_count   (error_count),
		.expected_left (expected_left)
	);

	task automatic write_reg(input logic idx, input logic [9:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_window(input logic [9:0] lo, input logic [9:0] hi);
		write_reg(fla_pkg::REG_ADC_LOW, lo);
		write_reg(fla_pkg::REG_ADC_HIGH, hi);
	endtask

	task automatic send_sample(input logic [9:0] raw);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, raw};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// drop valid and let every outstanding result come back
	task automatic end_phase();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_left != 0) @(negedge clk);
	endtask

	// receiver: random backpressure, plus one long hold-off on request
	initial begin : receiver
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 3);
			if (hold_request) begin
				hold_request = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_run <= 0;
		else
			idle_run <= idle_run + 1;
		if (idle_run >= STALL_LIMIT) begin
			$display("fuel_level_averager_test: done, errors");
			$finish;
		end
	end

	initial begin : stimulus
		int kind;
		int lo;
		int hi;
		logic [9:0] raw;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_addr     = fla_pkg::REG_ADC_LOW;
		cfg_wdata    = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		no_idle      = 1'b0;
		hold_request = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// full range, field extremes and alternating bit patterns
		set_window(10'd0, 10'd1023);
		send_sample(10'd0);
		send_sample(10'd1023);
		send_sample(10'h155);
		send_sample(10'h2AA);
		send_sample(10'd511);
		send_sample(10'd512);
		end_phase();
		// narrow window: below, on and above both bounds
		set_window(10'd100, 10'd900);
		send_sample(10'd50);
		send_sample(10'd100);
		send_sample(10'd900);
		send_sample(10'd1000);
		send_sample(10'd500);
		end_phase();
		// equal bounds
		set_window(10'd300, 10'd300);
		send_sample(10'd300);
		send_sample(10'd0);
		end_phase();
		// inverted bounds
		set_window(10'h2AA, 10'h155);
		send_sample(10'd512);
		send_sample(10'd1023);
		end_phase();
		set_window(10'd1023, 10'd1023);
		send_sample(10'd1023);
		end_phase();
		// one-step window at each end of the range
		set_window(10'd0, 10'd1);
		send_sample(10'd0);
		send_sample(10'd1);
		send_sample(10'd2);
		end_phase();
		set_window(10'd1022, 10'd1023);
		send_sample(10'd1022);
		send_sample(10'd1023);
		end_phase();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				lo = $urandom_range(0, 1023);
				hi = lo;
			end else if (kind == 1) begin
				hi = $urandom_range(0, 1022);
				lo = $urandom_range(hi + 1, 1023);
			end else if (kind == 2) begin
				lo = 0;
				hi = 1023;
			end else begin
				lo = $urandom_range(0, 1000);
				hi = $urandom_range(lo + 1, 1023);
			end
			set_window(10'(lo), 10'(hi));
			no_idle = (ph == 2) || (ph == 5);
			// first phase: receiver stalls long while samples keep coming
			if (ph == 0)
				hold_request = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 3) == 0)
					raw = ($urandom_range(0, 1) == 1) ? 10'(hi + $urandom_range(0, 2) - 1)
						: 10'(lo + $urandom_range(0, 2) - 1);
				else
					raw = 10'($urandom_range(0, 1023));
				send_sample(raw);
			end
			end_phase();
		end

		no_idle = 1'b0;
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("fuel_level_averager_test: done, clean");
		else
			$display("fuel_level_averager_test: done, errors");
		$finish;
	end

endmodule
